// ===== rtl/regula_falsi_root_step_defines.svh =====
// Assertion macros for the regula falsi root step checker.
// No dependencies.
`ifndef REGULA_FALSI_ROOT_STEP_DEFINES_SVH
`define REGULA_FALSI_ROOT_STEP_DEFINES_SVH

// Check a property while reset is released.
`define RFS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define RFS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/rfs_pkg.sv =====
// Shared types and constants of the regula falsi root step block.
// No dependencies.
`default_nettype none
package rfs_pkg;
    localparam logic [7:0]  STEP_LIMIT_RST = 8'd16;
    localparam logic [16:0] ONE_Q          = 17'h10000;
    localparam logic [16:0] HALF_Q         = 17'h08000;
    localparam logic        REG_STEP_LIMIT = 1'b0;

    typedef enum logic [1:0] {
        SIDE_NONE,
        SIDE_LOW,
        SIDE_HIGH,
        SIDE_DONE
    } t_side;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_CAPTURE,
        OP_DDIV_GO,
        OP_DMUL,
        OP_DWR,
        OP_MOVE,
        OP_SMUL1,
        OP_SMUL2,
        OP_SNUM,
        OP_SDIV_GO,
        OP_EMIT_LAST,
        OP_EMIT_FAULT,
        OP_EMIT_SEC
    } t_op;

    typedef struct packed {
        logic side_done;
        logic hit_any;
        logic need_damp;
        logic at_limit;
        logic den_zero;
        logic div_done;
    } t_status;
endpackage
`default_nettype wire

// ===== rtl/rfs_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies.
`default_nettype none
module rfs_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_go,
    input  wire logic [63:0] i_dividend,
    input  wire logic [32:0] i_divisor,
    output logic             o_done,
    output logic [63:0]      o_quotient
);
    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_q;
    logic [32:0] r_rem;
    logic [32:0] r_div;
    logic [33:0] trial;
    logic        ge;
    logic [33:0] n_rem;

    always_comb begin
        trial = {r_rem, r_q[63]};
        ge    = trial >= {1'b0, r_div};
        n_rem = ge ? (trial - {1'b0, r_div}) : trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_q    <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= n_rem[32:0];
                r_q   <= {r_q[62:0], ge};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;
endmodule
`default_nettype wire

// ===== rtl/rfs_dp.sv =====
// Datapath: bracket state, shared multiplier, divider and result register.
// Depends on rfs_pkg and rfs_div.
`default_nettype none
module rfs_dp (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire rfs_pkg::t_op       i_op,
    input  wire logic [7:0]         i_step_limit,
    input  wire logic signed [31:0] i_lower_point,
    input  wire logic signed [31:0] i_upper_point,
    input  wire logic signed [31:0] i_lower_value,
    input  wire logic signed [31:0] i_upper_value,
    input  wire logic signed [31:0] i_sample_value,
    output rfs_pkg::t_status        o_status,
    output logic signed [31:0]      o_point,
    output logic                    o_done_res,
    output logic                    o_fault
);
    logic signed [31:0] r_low, r_high, r_lv, r_hv, r_last, r_val;
    rfs_pkg::t_side     r_side;
    logic [7:0]         r_steps;
    logic signed [63:0] r_p1, r_prod, r_num;
    logic               r_neg;
    logic signed [31:0] r_point;
    logic               r_done, r_fault;

    logic               hit_low, hit_high;
    logic signed [31:0] ref_v, other_v;
    logic [31:0]        abs_val, abs_ref;
    logic signed [32:0] den;
    logic [32:0]        abs_den;
    logic [63:0]        abs_num;
    logic               div_go, div_done;
    logic [63:0]        div_a, quo;
    logic [32:0]        div_b;
    logic [16:0]        m;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p, adj;
    logic signed [31:0] sec_p;

    always_comb begin
        hit_low  = (r_val != 0) && (r_lv != 0) && (r_val[31] == r_lv[31]);
        hit_high = !hit_low && (r_val != 0) && (r_hv != 0) && (r_val[31] == r_hv[31]);
        ref_v    = hit_low ? r_lv : r_hv;
        other_v  = hit_low ? r_hv : r_lv;
        abs_val  = r_val[31] ? 32'(-r_val) : 32'(r_val);
        abs_ref  = ref_v[31] ? 32'(-ref_v) : 32'(ref_v);
        den      = {r_hv[31], r_hv} - {r_lv[31], r_lv};
        abs_den  = den[32] ? 33'(-den) : 33'(den);
        abs_num  = r_num[63] ? 64'(-r_num) : 64'(r_num);
        div_go   = (i_op == rfs_pkg::OP_DDIV_GO) || (i_op == rfs_pkg::OP_SDIV_GO);
        if (i_op == rfs_pkg::OP_DDIV_GO) begin
            div_a = {16'd0, abs_val, 16'd0};
            div_b = {1'b0, abs_ref};
        end else begin
            div_a = abs_num;
            div_b = abs_den;
        end
        m = (quo[63:16] != 0) ? rfs_pkg::HALF_Q : rfs_pkg::ONE_Q - {1'b0, quo[15:0]};
        case (i_op)
            rfs_pkg::OP_SMUL1: begin
                mul_a = r_low;
                mul_b = r_hv;
            end
            rfs_pkg::OP_SMUL2: begin
                mul_a = r_high;
                mul_b = r_lv;
            end
            default: begin
                mul_a = other_v;
                mul_b = $signed({15'd0, m});
            end
        endcase
        mul_p = mul_a * mul_b;
        adj   = r_prod + (r_prod[63] ? 64'sd65535 : 64'sd0);
        if (r_neg) begin
            sec_p = (quo[63:32] != 0 || (quo[31] && quo[30:0] != 0)) ?
                    32'sh80000000 : $signed(32'(-quo[31:0]));
        end else begin
            sec_p = (quo[63:31] != 0) ? 32'sh7FFFFFFF : $signed(quo[31:0]);
        end
    end

    rfs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (div_go),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low   <= '0;
            r_high  <= '0;
            r_lv    <= '0;
            r_hv    <= '0;
            r_last  <= '0;
            r_val   <= '0;
            r_side  <= rfs_pkg::SIDE_NONE;
            r_steps <= '0;
        end else begin
            case (i_op)
                rfs_pkg::OP_LOAD: begin
                    r_low   <= i_lower_point;
                    r_high  <= i_upper_point;
                    r_lv    <= i_lower_value;
                    r_hv    <= i_upper_value;
                    r_steps <= '0;
                    r_side  <= rfs_pkg::SIDE_NONE;
                end
                rfs_pkg::OP_CAPTURE: begin
                    r_val <= i_sample_value;
                    if (r_side != rfs_pkg::SIDE_DONE && r_steps != 8'd255) begin
                        r_steps <= r_steps + 8'd1;
                    end
                end
                rfs_pkg::OP_DWR: begin
                    if (hit_low) begin
                        r_hv <= adj[47:16];
                    end else begin
                        r_lv <= adj[47:16];
                    end
                end
                rfs_pkg::OP_MOVE: begin
                    if (hit_low) begin
                        r_low  <= r_last;
                        r_lv   <= r_val;
                        r_side <= rfs_pkg::SIDE_LOW;
                    end else begin
                        r_high <= r_last;
                        r_hv   <= r_val;
                        r_side <= rfs_pkg::SIDE_HIGH;
                    end
                end
                rfs_pkg::OP_EMIT_LAST: begin
                    r_side <= rfs_pkg::SIDE_DONE;
                end
                rfs_pkg::OP_EMIT_FAULT: begin
                    r_side <= rfs_pkg::SIDE_DONE;
                    r_last <= r_low;
                end
                rfs_pkg::OP_EMIT_SEC: begin
                    r_last <= sec_p;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            rfs_pkg::OP_SMUL1: begin
                r_p1 <= mul_p;
            end
            rfs_pkg::OP_SMUL2, rfs_pkg::OP_DMUL: begin
                r_prod <= mul_p;
            end
            rfs_pkg::OP_SNUM: begin
                r_num <= r_p1 - r_prod;
            end
            rfs_pkg::OP_SDIV_GO: begin
                r_neg <= r_num[63] ^ den[32];
            end
            rfs_pkg::OP_EMIT_LAST: begin
                r_point <= r_last;
                r_done  <= 1'b1;
                r_fault <= 1'b0;
            end
            rfs_pkg::OP_EMIT_FAULT: begin
                r_point <= r_low;
                r_done  <= 1'b0;
                r_fault <= 1'b1;
            end
            rfs_pkg::OP_EMIT_SEC: begin
                r_point <= sec_p;
                r_done  <= 1'b0;
                r_fault <= 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_status.side_done = (r_side == rfs_pkg::SIDE_DONE);
        o_status.hit_any   = hit_low || hit_high;
        o_status.need_damp = (hit_low && r_side == rfs_pkg::SIDE_LOW) ||
                             (hit_high && r_side == rfs_pkg::SIDE_HIGH);
        o_status.at_limit  = r_steps >= i_step_limit;
        o_status.den_zero  = (den == 0);
        o_status.div_done  = div_done;
    end

    assign o_point    = r_point;
    assign o_done_res = r_done;
    assign o_fault    = r_fault;
endmodule
`default_nettype wire

// ===== rtl/rfs_ctrl.sv =====
// Controller state machine: sequences the datapath and owns both handshakes.
// Depends on rfs_pkg.
`default_nettype none
module rfs_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_operation,
    input  wire logic             i_out_ready,
    input  wire rfs_pkg::t_status i_status,
    output rfs_pkg::t_op          o_op,
    output logic                  o_in_ready,
    output logic                  o_out_valid
);
    typedef enum logic [3:0] {
        S_IDLE, S_VCHK, S_DDIV, S_DWAIT, S_DMUL, S_DWR, S_MOVE, S_LIMIT,
        S_SMUL1, S_SMUL2, S_SNUM, S_SDIV, S_SWAIT, S_EM_LAST, S_EM_FAULT, S_EM_SEC
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    always_comb begin
        slot_free   = !r_out_valid || i_out_ready;
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_op        = rfs_pkg::OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_op    = i_operation ? rfs_pkg::OP_CAPTURE : rfs_pkg::OP_LOAD;
                    n_state = i_operation ? S_VCHK : S_SMUL1;
                end
            end
            S_VCHK: begin
                if (i_status.side_done || !i_status.hit_any) begin
                    n_state = S_EM_LAST;
                end else if (i_status.need_damp) begin
                    n_state = S_DDIV;
                end else begin
                    n_state = S_MOVE;
                end
            end
            S_DDIV: begin
                o_op    = rfs_pkg::OP_DDIV_GO;
                n_state = S_DWAIT;
            end
            S_DWAIT: begin
                if (i_status.div_done) begin
                    n_state = S_DMUL;
                end
            end
            S_DMUL: begin
                o_op    = rfs_pkg::OP_DMUL;
                n_state = S_DWR;
            end
            S_DWR: begin
                o_op    = rfs_pkg::OP_DWR;
                n_state = S_MOVE;
            end
            S_MOVE: begin
                o_op    = rfs_pkg::OP_MOVE;
                n_state = S_LIMIT;
            end
            S_LIMIT: begin
                n_state = i_status.at_limit ? S_EM_LAST : S_SMUL1;
            end
            S_SMUL1: begin
                o_op    = rfs_pkg::OP_SMUL1;
                n_state = S_SMUL2;
            end
            S_SMUL2: begin
                o_op    = rfs_pkg::OP_SMUL2;
                n_state = S_SNUM;
            end
            S_SNUM: begin
                o_op    = rfs_pkg::OP_SNUM;
                n_state = S_SDIV;
            end
            S_SDIV: begin
                if (i_status.den_zero) begin
                    n_state = S_EM_FAULT;
                end else begin
                    o_op    = rfs_pkg::OP_SDIV_GO;
                    n_state = S_SWAIT;
                end
            end
            S_SWAIT: begin
                if (i_status.div_done) begin
                    n_state = S_EM_SEC;
                end
            end
            S_EM_LAST, S_EM_FAULT, S_EM_SEC: begin
                if (slot_free) begin
                    case (r_state)
                        S_EM_LAST:  o_op = rfs_pkg::OP_EMIT_LAST;
                        S_EM_FAULT: o_op = rfs_pkg::OP_EMIT_FAULT;
                        default:    o_op = rfs_pkg::OP_EMIT_SEC;
                    endcase
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
endmodule
`default_nettype wire

// ===== rtl/regula_falsi_root_step.sv =====
// Top level of the Anderson-Bjorck regula falsi root step block.
// Depends on rfs_pkg, rfs_ctrl and rfs_dp.
// A value item ends in a repeat or zero hit, the step limit, a plain or a damped step.
// One transaction at a time, paced by the serial divider.
// Reset: synchronous, active low; clears bracket state, step_limit to 16.
`default_nettype none
module regula_falsi_root_step (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_operation,
    input  wire logic signed [31:0] i_lower_point,
    input  wire logic signed [31:0] i_upper_point,
    input  wire logic signed [31:0] i_lower_value,
    input  wire logic signed [31:0] i_upper_value,
    input  wire logic signed [31:0] i_sample_value,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [31:0]      o_point,
    output logic                    o_done_res,
    output logic                    o_fault,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    logic [7:0]       r_step_limit;
    rfs_pkg::t_op     op;
    rfs_pkg::t_status status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_limit <= rfs_pkg::STEP_LIMIT_RST;
        end else if (psel && penable && pwrite && paddr[2] == rfs_pkg::REG_STEP_LIMIT) begin
            r_step_limit <= pwdata[7:0];
        end
    end

    assign prdata = (paddr[2] == rfs_pkg::REG_STEP_LIMIT) ? {24'd0, r_step_limit} : 32'd0;
    assign pready = 1'b1;

    rfs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_op        (op),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid)
    );

    rfs_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (op),
        .i_step_limit   (r_step_limit),
        .i_lower_point  (i_lower_point),
        .i_upper_point  (i_upper_point),
        .i_lower_value  (i_lower_value),
        .i_upper_value  (i_upper_value),
        .i_sample_value (i_sample_value),
        .o_status       (status),
        .o_point        (o_point),
        .o_done_res     (o_done_res),
        .o_fault        (o_fault)
    );
endmodule
`default_nettype wire

// ===== rtl/rfs_chk.sv =====
// Port-level checker for regula_falsi_root_step, bound to the top level.
// Depends on regula_falsi_root_step_defines.svh.
`default_nettype none
`include "regula_falsi_root_step_defines.svh"
module rfs_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] o_point,
    input wire logic        o_done_res,
    input wire logic        o_fault,
    input wire logic        pready
);
    `RFS_ASSERT(a_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_point), "result dropped or changed while stalled")
    `RFS_ASSERT(a_flags, o_out_valid |-> !(o_done_res && o_fault), "done and fault together")
    `RFS_ASSERT(a_busy, i_in_valid && o_in_ready |=> !o_in_ready, "second transaction taken while busy")
    `RFS_ASSERT_ALWAYS(a_rst, !i_rst_n |=> !o_out_valid, "result valid after reset")
    `RFS_ASSERT_ALWAYS(a_pready, pready, "pready low")
endmodule

bind regula_falsi_root_step rfs_chk u_chk (.*);
`default_nettype wire

// ===== dv/regula_falsi_root_step_checker.sv =====
// Checker for the regula falsi root step block: predicts each result from the
// accepted input transactions and compares it. Depends on rfs_pkg.
module regula_falsi_root_step_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic               i_operation,
    input  logic signed [31:0] i_lower_point,
    input  logic signed [31:0] i_upper_point,
    input  logic signed [31:0] i_lower_value,
    input  logic signed [31:0] i_upper_value,
    input  logic signed [31:0] i_sample_value,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [31:0] i_point,
    input  logic               i_done_res,
    input  logic               i_fault,
    input  logic               i_cfg_write,
    input  logic [7:0]         i_cfg_limit,
    output int                 o_failures,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [31:0] point;
        logic               done_res;
        logic               fault;
    } t_root_result;

    t_root_result       root_queue[$];
    logic [7:0]         limit_q;
    logic signed [63:0] lo_c, hi_c, lo_f, hi_f, last_c;
    rfs_pkg::t_side     side_q;
    logic [7:0]         steps_q;

    function automatic logic signed [63:0] scale_value(
        logic signed [63:0] other, logic signed [63:0] val, logic signed [63:0] ref_f);
        logic signed [63:0] m;
        m = 64'sd65536 - (val * 64'sd65536) / ref_f;
        if (m <= 0) m = 64'sd32768;
        return (other * m) / 64'sd65536;
    endfunction

    function automatic int sgn(logic signed [63:0] v);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    task automatic predict_root;
        t_root_result r;
        logic signed [63:0] val, den, q;
        int sv;
        logic finish;
        finish = 1'b0;
        if (!i_operation) begin
            lo_c = i_lower_point;
            hi_c = i_upper_point;
            lo_f = i_lower_value;
            hi_f = i_upper_value;
            steps_q = 0;
            side_q = rfs_pkg::SIDE_NONE;
        end else if (side_q == rfs_pkg::SIDE_DONE) begin
            finish = 1'b1;
        end else begin
            val = i_sample_value;
            if (steps_q != 8'd255) steps_q++;
            sv = sgn(val);
            if (sv != 0 && sv == sgn(lo_f)) begin
                lo_c = last_c;
                if (side_q == rfs_pkg::SIDE_LOW) hi_f = scale_value(hi_f, val, lo_f);
                lo_f = val;
                side_q = rfs_pkg::SIDE_LOW;
            end else if (sv != 0 && sv == sgn(hi_f)) begin
                hi_c = last_c;
                if (side_q == rfs_pkg::SIDE_HIGH) lo_f = scale_value(lo_f, val, hi_f);
                hi_f = val;
                side_q = rfs_pkg::SIDE_HIGH;
            end else begin
                side_q = rfs_pkg::SIDE_DONE;
                finish = 1'b1;
            end
            if (!finish && steps_q >= limit_q) begin
                side_q = rfs_pkg::SIDE_DONE;
                finish = 1'b1;
            end
        end
        if (finish) begin
            r = '{point: last_c[31:0], done_res: 1'b1, fault: 1'b0};
        end else begin
            den = hi_f - lo_f;
            if (den == 0) begin
                last_c = lo_c;
                side_q = rfs_pkg::SIDE_DONE;
                r = '{point: lo_c[31:0], done_res: 1'b0, fault: 1'b1};
            end else begin
                q = (lo_c * hi_f - hi_c * lo_f) / den;
                if (q > 64'sh7fffffff) q = 64'sh7fffffff;
                if (q < -64'sh80000000) q = -64'sh80000000;
                last_c = q;
                r = '{point: q[31:0], done_res: 1'b0, fault: 1'b0};
            end
        end
        root_queue.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_root_result e;
        int nf;
        nf = 0;
        if (!i_rst_n) begin
            limit_q <= rfs_pkg::STEP_LIMIT_RST;
            lo_c = 0; hi_c = 0; lo_f = 0; hi_f = 0; last_c = 0;
            side_q = rfs_pkg::SIDE_NONE;
            steps_q = 0;
            root_queue.delete();
            o_failures <= 0;
        end else begin
            if (i_cfg_write) limit_q <= i_cfg_limit;
            if (i_in_valid && i_in_ready) predict_root();
            if (i_out_valid && i_out_ready) begin
                if (root_queue.size() == 0) begin
                    $error("unexpected result point %h", i_point);
                    nf++;
                end else begin
                    e = root_queue.pop_front();
                    if (e.point !== i_point) begin
                        $error("point expected %h actual %h", e.point, i_point);
                        nf++;
                    end
                    if (e.done_res !== i_done_res) begin
                        $error("done_res expected %b actual %b", e.done_res, i_done_res);
                        nf++;
                    end
                    if (e.fault !== i_fault) begin
                        $error("fault expected %b actual %b", e.fault, i_fault);
                        nf++;
                    end
                end
            end
            o_failures <= o_failures + nf;
        end
    end

    assign o_pending = root_queue.size();
endmodule

// ===== dv/regula_falsi_root_step_test.sv =====
// Testbench top for the regula falsi root step block: drives brackets,
// samples and step_limit writes. Depends on regula_falsi_root_step and the checker module.
module regula_falsi_root_step_test;
    timeunit 1ns;
    timeprecision 1ps;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic               i_operation = 1'b0;
    logic signed [31:0] i_lower_point = '0, i_upper_point = '0;
    logic signed [31:0] i_lower_value = '0, i_upper_value = '0;
    logic signed [31:0] i_sample_value = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [31:0] o_point;
    logic               o_done_res, o_fault;
    logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    int                 failures, pending;
    logic               stim_done = 1'b0;
    logic signed [31:0] last_pt;

    always #1 i_clk = ~i_clk;

    regula_falsi_root_step uut (.*);

    regula_falsi_root_step_checker checker_i (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_ready(o_in_ready), .i_operation,
        .i_lower_point, .i_upper_point, .i_lower_value, .i_upper_value,
        .i_sample_value, .i_out_valid(o_out_valid), .i_out_ready,
        .i_point(o_point), .i_done_res(o_done_res), .i_fault(o_fault),
        .i_cfg_write(psel && penable && pwrite && pready), .i_cfg_limit(pwdata[7:0]),
        .o_failures(failures), .o_pending(pending)
    );

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    endfunction

    function automatic logic signed [31:0] rand_q();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $signed($urandom_range(0, 2 * 65536 * 8)) - 32'sd524288;
            2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed($urandom_range(0, 65536 * 200)) - 32'sd6553600;
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n || !stim_done) i_out_ready <= ($urandom_range(0, 9) < 7);
        else i_out_ready <= 1'b1;
    end

    always @(posedge i_clk) if (o_out_valid && i_out_ready) last_pt <= o_point;

    task automatic write_limit(logic [7:0] v);
        repeat (150) @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'd0; pwdata <= {24'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send(logic op, logic signed [31:0] a, logic signed [31:0] b,
                        logic signed [31:0] fa, logic signed [31:0] fb,
                        logic signed [31:0] s);
        repeat (gap_len() + 1) @(posedge i_clk);
        i_in_valid <= 1'b1; i_operation <= op;
        i_lower_point <= a; i_upper_point <= b;
        i_lower_value <= fa; i_upper_value <= fb; i_sample_value <= s;
        do @(posedge i_clk); while (!o_in_ready);
        i_in_valid <= 1'b0;
    endtask

    task automatic drain;
        do @(negedge i_clk); while (pending != 0);
    endtask

    task automatic run_search(int nvals);
        logic signed [31:0] a, b, fa, fb, r;
        a = $signed($urandom_range(0, 65536 * 20)) - 32'sd655360;
        b = a + $signed($urandom_range(1, 65536 * 20));
        r = a + $signed($urandom_range(0, b - a));
        fa = (a - r) * $signed($urandom_range(1, 4));
        fb = (b - r) * $signed($urandom_range(1, 4));
        if ($urandom_range(0, 9) == 0) begin
            a = rand_q(); b = rand_q(); fa = rand_q(); fb = rand_q();
        end
        send(1'b0, a, b, fa, fb, rand_q());
        for (int k = 0; k < nvals; k++) begin
            drain();
            @(posedge i_clk);
            if ($urandom_range(0, 9) == 0)
                send(1'b1, rand_q(), rand_q(), rand_q(), rand_q(), rand_q());
            else
                send(1'b1, rand_q(), rand_q(), rand_q(), rand_q(),
                     (last_pt - r) * $signed($urandom_range(1, 3)) +
                     $signed($urandom_range(0, 7)) - 32'sd3);
        end
    endtask

    initial begin
        int items;
        logic [7:0] lims[4];
        lims = '{8'd1, 8'd255, 8'd0, 8'd5};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send(1'b1, 0, 0, 0, 0, 32'sd100);
        send(1'b1, 0, 0, 0, 0, 32'sd100);
        send(1'b0, -32'sd65536, 32'sd65536, -32'sd65536, 32'sd65536, 0);
        send(1'b1, 0, 0, 0, 0, 0);
        send(1'b1, 0, 0, 0, 0, 5);
        send(1'b0, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 0);
        send(1'b0, 32'sh7fffffff, 32'sh80000000, 32'sd1, 32'sh80000000, 0);
        send(1'b0, 5, 9, 32'sd7, 32'sd7, 0);
        send(1'b0, 0, 32'sd131072, -32'sd65536, 32'sd65536, 0);
        send(1'b1, 0, 0, 0, 0, -32'sd1000);
        send(1'b1, 0, 0, 0, 0, -32'sd500);
        send(1'b1, 0, 0, 0, 0, -32'sd100);
        send(1'b1, 0, 0, 0, 0, 32'sd70000);
        send(1'b1, 0, 0, 0, 0, 32'sh80000000);
        send(1'b1, 0, 0, 0, 0, 32'sh7fffffff);
        send(1'b1, 0, 0, 0, 0, 32'sd1);
        items = 16;
        for (int ph = 0; ph < 5; ph++) begin
            drain();
            if (ph < 4) write_limit(lims[ph]);
            else write_limit(8'd16);
            while (items < 16 + (ph + 1) * 350) begin
                int n;
                n = $urandom_range(0, 8);
                run_search(n);
                items += n + 1;
            end
        end
        drain();
        repeat (200) @(posedge i_clk);
        stim_done <= 1'b1;
        @(posedge i_clk);
        if (failures == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("Some tests failed");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/rfs_pkg.sv
rtl/rfs_div.sv
rtl/rfs_dp.sv
rtl/rfs_ctrl.sv
rtl/regula_falsi_root_step.sv
rtl/rfs_chk.sv
dv/regula_falsi_root_step_checker.sv
dv/regula_falsi_root_step_test.sv
